>>> rtl/core/bcis_pkg.sv
// shared types, codes and sizes for the basic computer instruction step block
// no dependencies; imported by bcis_alu and the top level of the block
package bcis_pkg;

   localparam int ADDR_BITS = 12;
   localparam int MEM_WORDS = 1 << ADDR_BITS;
   localparam int DATA_BITS = 16;
   localparam int PC_BITS   = 12;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_STEP    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_UNUSED  = 2'd3
   } command_type;

   // memory-reference opcodes, bits 14:12 of the instruction
   typedef enum logic [2:0] {
      OP_AND = 3'd0,
      OP_ADD = 3'd1,
      OP_LDA = 3'd2,
      OP_STA = 3'd3,
      OP_BUN = 3'd4,
      OP_BSA = 3'd5,
      OP_ISZ = 3'd6,
      OP_REG = 3'd7
   } opcode_type;

   // register-reference function bits, low 12 bits of the instruction
   localparam logic [11:0] REG_CLA = 12'h800;
   localparam logic [11:0] REG_CLE = 12'h400;
   localparam logic [11:0] REG_CMA = 12'h200;
   localparam logic [11:0] REG_CME = 12'h100;
   localparam logic [11:0] REG_CIR = 12'h080;
   localparam logic [11:0] REG_CIL = 12'h040;
   localparam logic [11:0] REG_INC = 12'h020;
   localparam logic [11:0] REG_SPA = 12'h010;
   localparam logic [11:0] REG_SNA = 12'h008;
   localparam logic [11:0] REG_SZA = 12'h004;
   localparam logic [11:0] REG_SZE = 12'h002;
   localparam logic [11:0] REG_HLT = 12'h001;

   typedef enum logic [2:0] {
      ALU_AND    = 3'd0,
      ALU_ADD    = 3'd1,
      ALU_PASS_B = 3'd2,
      ALU_INC_A  = 3'd3,
      ALU_INC_B  = 3'd4,
      ALU_CMA    = 3'd5,
      ALU_CIR    = 3'd6,
      ALU_CIL    = 3'd7
   } alu_op_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] value;
      logic                 carry;
      logic                 zero;
   } alu_out_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [11:0] address;
      logic [15:0] data;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] program_counter;
      logic [15:0] accumulator;
      logic        extend_bit;
      logic        halted;
      logic        executed;
      logic [15:0] instruction_word;
   } rsp_payload_type;

endpackage

>>> rtl/core/bcis_ram.sv
// generic single-port ram with registered read
// no package dependencies
module bcis_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/bcis_alu.sv
// shared accumulator unit: logic, add, increment, complement and rotate
// depends on bcis_pkg for the operation codes and result struct
module bcis_alu import bcis_pkg::*; (
   input  alu_op_type           op,
   input  logic [DATA_BITS-1:0] a,
   input  logic [DATA_BITS-1:0] b,
   input  logic                 carry,
   output alu_out_type          result
);

   logic [DATA_BITS:0] sum;

   always_comb begin
      sum          = {1'b0, a} + {1'b0, b};
      result.value = b;
      result.carry = carry;
      case (op)
         ALU_AND: result.value = a & b;
         ALU_ADD: begin
            result.value = sum[DATA_BITS-1:0];
            result.carry = sum[DATA_BITS];
         end
         ALU_PASS_B: result.value = b;
         ALU_INC_A:  result.value = a + DATA_BITS'(1);
         ALU_INC_B:  result.value = b + DATA_BITS'(1);
         ALU_CMA:    result.value = ~a;
         ALU_CIR: begin
            result.value = {carry, a[DATA_BITS-1:1]};
            result.carry = a[0];
         end
         ALU_CIL: begin
            result.value = {a[DATA_BITS-2:0], carry};
            result.carry = a[DATA_BITS-1];
         end
         default: result.value = b;
      endcase
      result.zero = (result.value == '0);
   end

endmodule

>>> rtl/core/basic_computer_instruction_step.sv
// top level: sequencer, machine registers and result register of the step block
// depends on bcis_pkg, bcis_ram and bcis_alu
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_payload_type
//  rsp      out        rsp_valid / rsp_stall  rsp_payload_type
//  csr      in         csr_valid / csr_ready  csr_data, start address
//
// write and restart pass through the done state to the result, a halted step too
// a step: fetch, decode, done for a register word; a memory word adds oper,
// and exec for and, add, lda and isz, and indir and ptr first if indirect;
// fetch, pointer read, operand read and write-back share the one ram port and alu
// reset is synchronous; the machine comes up running at pc zero
// a result waiting on rsp_stall holds the next one in the done state
module basic_computer_instruction_step import bcis_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [11:0]     csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_DECODE,
      S_INDIR,
      S_PTR,
      S_OPER,
      S_EXEC,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_BITS-1:0]   pc_ff, pc_in;
   logic [ADDR_BITS-1:0]   ar_ff, ar_in;
   logic [ADDR_BITS-1:0]   start_ff, start_in;
   logic [DATA_BITS-1:0]   acc_ff, acc_in;
   logic                   ext_ff, ext_in;
   logic                   run_ff, run_in;
   logic [DATA_BITS-1:0]   ir_ff, ir_in;
   logic                   exec_ff, exec_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_ff, rsp_in;

   logic                   req_xfer;
   logic                   rsp_free;
   logic [ADDR_BITS-1:0]   pc_plus1;
   logic [ADDR_BITS-1:0]   pc_plus2;
   opcode_type             dec_op;
   opcode_type             ir_op;
   logic                   ram_we;
   logic [ADDR_BITS-1:0]   ram_addr;
   logic [DATA_BITS-1:0]   ram_wdata;
   logic [DATA_BITS-1:0]   ram_rdata;
   alu_op_type             alu_op;
   alu_out_type            alu_res;

   bcis_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   bcis_alu u_alu (
      .op     (alu_op),
      .a      (acc_ff),
      .b      (ram_rdata),
      .carry  (ext_ff),
      .result (alu_res)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign pc_plus1 = pc_ff + ADDR_BITS'(1);
   assign pc_plus2 = pc_ff + ADDR_BITS'(2);
   assign dec_op   = opcode_type'(ram_rdata[14:12]);
   assign ir_op    = opcode_type'(ir_ff[14:12]);

   // alu operation follows the state that owns the unit this cycle
   always_comb begin
      alu_op = ALU_PASS_B;
      case (state_ff)
         S_DECODE: begin
            case (ram_rdata[11:0])
               REG_CMA: alu_op = ALU_CMA;
               REG_CIR: alu_op = ALU_CIR;
               REG_CIL: alu_op = ALU_CIL;
               REG_INC: alu_op = ALU_INC_A;
               default: alu_op = ALU_PASS_B;
            endcase
         end
         S_EXEC: begin
            case (ir_op)
               OP_AND:  alu_op = ALU_AND;
               OP_ADD:  alu_op = ALU_ADD;
               OP_ISZ:  alu_op = ALU_INC_B;
               default: alu_op = ALU_PASS_B;
            endcase
         end
         default: alu_op = ALU_PASS_B;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      ar_in        = ar_ff;
      acc_in       = acc_ff;
      ext_in       = ext_ff;
      run_in       = run_ff;
      ir_in        = ir_ff;
      exec_in      = exec_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      start_in     = start_ff;
      ram_we       = 1'b0;
      ram_addr     = pc_ff;
      ram_wdata    = acc_ff;

      if (csr_valid && csr_ready) begin
         start_in = csr_data[ADDR_BITS-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               ir_in    = '0;
               exec_in  = 1'b0;
               state_in = S_DONE;
               case (command_type'(req_payload.command))
                  CMD_WRITE: begin
                     ram_we    = 1'b1;
                     ram_addr  = req_payload.address[ADDR_BITS-1:0];
                     ram_wdata = req_payload.data;
                  end
                  CMD_RESTART: begin
                     pc_in  = start_ff;
                     run_in = 1'b1;
                  end
                  CMD_STEP: begin
                     if (run_ff) begin
                        state_in = S_FETCH;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_FETCH: begin
            ram_addr = pc_ff;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            ir_in   = ram_rdata;
            exec_in = 1'b1;
            pc_in   = pc_plus1;
            ar_in   = ram_rdata[ADDR_BITS-1:0];
            if (dec_op == OP_REG) begin
               state_in = S_DONE;
               // io words fall through with no effect
               if (!ram_rdata[15]) begin
                  case (ram_rdata[11:0])
                     REG_CLA: acc_in = '0;
                     REG_CLE: ext_in = 1'b0;
                     REG_CMA: acc_in = alu_res.value;
                     REG_CME: ext_in = !ext_ff;
                     REG_CIR: begin
                        acc_in = alu_res.value;
                        ext_in = alu_res.carry;
                     end
                     REG_CIL: begin
                        acc_in = alu_res.value;
                        ext_in = alu_res.carry;
                     end
                     REG_INC: acc_in = alu_res.value;
                     REG_SPA: if (!acc_ff[DATA_BITS-1]) pc_in = pc_plus2;
                     REG_SNA: if (acc_ff[DATA_BITS-1]) pc_in = pc_plus2;
                     REG_SZA: if (acc_ff == '0) pc_in = pc_plus2;
                     REG_SZE: if (!ext_ff) pc_in = pc_plus2;
                     REG_HLT: run_in = 1'b0;
                     default: run_in = run_ff;
                  endcase
               end
            end else if (ram_rdata[15]) begin
               state_in = S_INDIR;
            end else begin
               state_in = S_OPER;
            end
         end
         S_INDIR: begin
            ram_addr = ar_ff;
            state_in = S_PTR;
         end
         S_PTR: begin
            ar_in    = ram_rdata[ADDR_BITS-1:0];
            state_in = S_OPER;
         end
         S_OPER: begin
            ram_addr = ar_ff;
            state_in = S_DONE;
            case (ir_op)
               OP_STA: begin
                  ram_we    = 1'b1;
                  ram_wdata = acc_ff;
               end
               OP_BUN: pc_in = ar_ff;
               OP_BSA: begin
                  ram_we    = 1'b1;
                  ram_wdata = DATA_BITS'(pc_ff);
                  pc_in     = ar_ff + ADDR_BITS'(1);
               end
               default: state_in = S_EXEC;
            endcase
         end
         S_EXEC: begin
            ram_addr = ar_ff;
            state_in = S_DONE;
            case (ir_op)
               OP_AND: acc_in = alu_res.value;
               OP_ADD: begin
                  acc_in = alu_res.value;
                  ext_in = alu_res.carry;
               end
               OP_LDA: acc_in = alu_res.value;
               OP_ISZ: begin
                  // write back the incremented word and skip on wrap to zero
                  ram_we    = 1'b1;
                  ram_wdata = alu_res.value;
                  if (alu_res.zero) begin
                     pc_in = pc_plus1;
                  end
               end
               default: acc_in = acc_ff;
            endcase
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_in.program_counter  = PC_BITS'(pc_ff);
               rsp_in.accumulator      = acc_ff;
               rsp_in.extend_bit       = ext_ff;
               rsp_in.halted           = !run_ff;
               rsp_in.executed         = exec_ff;
               rsp_in.instruction_word = ir_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         acc_ff       <= '0;
         ext_ff       <= 1'b0;
         run_ff       <= 1'b1;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         ext_ff       <= ext_in;
         run_ff       <= run_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ar_ff   <= ar_in;
      ir_ff   <= ir_in;
      exec_ff <= exec_in;
      rsp_ff  <= rsp_in;
   end

   // a memory write in idle only comes from a write command transfer
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == S_IDLE) |-> (req_xfer && req_payload.command == CMD_WRITE))
      else $error("memory written in idle without a write transfer");

   // a step while halted goes straight to the result
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_payload.command == CMD_STEP && !run_ff) |=> (state_ff == S_DONE))
      else $error("halted step started a fetch");

   // decode always sees the word fetched in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE) |-> ($past(state_ff) == S_FETCH))
      else $error("decode entered without a fetch");

   // a new result appears only out of the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the done state");

endmodule
